/* design/sra_pkg.sv */
// ----------------------------------------------------------------------------
// sra_pkg
// shared types, codes and helpers of the selective-repeat window controller
// ----------------------------------------------------------------------------
package sra_pkg;

    // sequence space is the full 6-bit range, so modulo arithmetic wraps
    localparam int SEQ_W   = 6;
    localparam int SEQ_MAX = 63;
    // window is a power of two, so the slot of a sequence is its low bits
    localparam int WIN     = 32;
    localparam int SLOT_W  = $clog2(WIN);
    localparam int CNT_W   = $clog2(WIN + 1);
    localparam int RUN_W   = 6;

    // result queue of one event
    localparam int MAX_RES = 4;
    localparam int Q_IDX_W = $clog2(MAX_RES);
    localparam int Q_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [CNT_W-1:0] WIN_CNT   = CNT_W'(WIN);
    localparam logic [SEQ_W-1:0] RECV_UP_0 = SEQ_W'(WIN % (SEQ_MAX + 1));

    // event codes
    localparam logic [2:0] MODE_PKT   = 3'd0;
    localparam logic [2:0] MODE_PHY   = 3'd1;
    localparam logic [2:0] MODE_FRAME = 3'd2;
    localparam logic [2:0] MODE_DTO   = 3'd3;
    localparam logic [2:0] MODE_ATO   = 3'd4;

    // received frame kinds
    localparam logic [1:0] FT_DATA = 2'd0;
    localparam logic [1:0] FT_ACK  = 2'd1;
    localparam logic [1:0] FT_NAK  = 2'd2;

    // result actions
    localparam logic [2:0] ACT_STATUS  = 3'd0;
    localparam logic [2:0] ACT_DATA    = 3'd1;
    localparam logic [2:0] ACT_ACK     = 3'd2;
    localparam logic [2:0] ACT_NAK     = 3'd3;
    localparam logic [2:0] ACT_DELIVER = 3'd4;
    localparam logic [2:0] ACT_RELEASE = 3'd5;

    // datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_EVENT   = 3'd1;
    localparam logic [OP_W-1:0] OP_WALK    = 3'd2;
    localparam logic [OP_W-1:0] OP_NAKDATA = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;
    localparam logic [OP_W-1:0] OP_FILL    = 3'd5;

    typedef struct packed {
        logic [2:0]       mode;
        logic             frame_good;
        logic [1:0]       frame_type;
        logic [SEQ_W-1:0] rx_seq;
        logic [SEQ_W-1:0] rx_ack;
        logic [SEQ_W-1:0] timeout_seq;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       action;
        logic [SEQ_W-1:0] seq_out;
        logic [SEQ_W-1:0] ack_out;
        logic [RUN_W-1:0] run_length;
        logic             start_data_timer;
        logic             restart_ack_timer;
        logic             halt_ack_timer;
        logic             net_enable;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic            load;
        logic            pop;
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic frame_ok;
        logic walk_act;
        logic head_last;
    } t_stat;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] v);
        return (v < SEQ_W'(SEQ_MAX)) ? v + SEQ_W'(1) : '0;
    endfunction

    function automatic logic [SEQ_W-1:0] seq_dec(input logic [SEQ_W-1:0] v);
        return (v == '0) ? SEQ_W'(SEQ_MAX) : v - SEQ_W'(1);
    endfunction

    // b lies in the circular half-open interval [a, c)
    function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (b < c)) || ((c < a) && (a <= b));
    endfunction

    function automatic t_out_item mk_res(input logic [2:0]       action,
                                         input logic [SEQ_W-1:0] seq,
                                         input logic [RUN_W-1:0] run,
                                         input logic             sdt,
                                         input logic             rat,
                                         input logic             hat,
                                         input logic [SEQ_W-1:0] ack);
        t_out_item r;
        r.action            = action;
        r.seq_out           = seq;
        r.ack_out           = ack;
        r.run_length        = run;
        r.start_data_timer  = sdt;
        r.restart_ack_timer = rat;
        r.halt_ack_timer    = hat;
        r.net_enable        = 1'b0;
        r.last              = 1'b0;
        return r;
    endfunction

endpackage

/* design/sra_dpath.sv */
// ----------------------------------------------------------------------------
// sra_dpath
// window state, arrived bitmap, delivery walk and per-event result queue
// ----------------------------------------------------------------------------
module sra_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sra_pkg::t_cmd     i_cmd,
    input  sra_pkg::t_in_item i_in_item,
    output sra_pkg::t_stat    o_stat,
    output sra_pkg::t_out_item o_out_item
);
    import sra_pkg::*;

    t_in_item         r_item;
    logic [SEQ_W-1:0] r_send_lower, n_send_lower;
    logic [SEQ_W-1:0] r_send_next,  n_send_next;
    logic [SEQ_W-1:0] r_recv_lower, n_recv_lower;
    logic [SEQ_W-1:0] r_recv_upper, n_recv_upper;
    logic [WIN-1:0]   r_slot_arrived, n_slot_arrived;
    logic [CNT_W-1:0] r_outstanding, n_outstanding;
    logic             r_nak_allowed, n_nak_allowed;
    logic             r_phys_ready,  n_phys_ready;
    logic             r_walk_act,    n_walk_act;
    logic [SEQ_W-1:0] r_walk_first,  n_walk_first;
    logic [CNT_W-1:0] r_walk_n,      n_walk_n;
    t_out_item        r_q [MAX_RES];
    logic [Q_CNT_W-1:0] r_q_cnt,  n_q_cnt;
    logic [Q_IDX_W-1:0] r_q_head, n_q_head;

    logic             w_push;
    t_out_item        w_push_item;
    logic [SEQ_W-1:0] w_ack_now;
    logic [SEQ_W-1:0] w_lost;
    logic             w_lost_hit;
    logic             w_rel_hit;
    logic [SEQ_W-1:0] w_rel_n;
    logic [SLOT_W-1:0] w_seq_slot;
    logic [SLOT_W-1:0] w_walk_slot;
    logic             w_head_last;
    t_out_item        w_head;

    always_comb begin
        w_ack_now   = seq_dec(r_recv_lower);
        w_lost      = seq_inc(r_item.rx_ack);
        w_lost_hit  = in_window(r_send_lower, w_lost, r_send_next);
        w_rel_hit   = in_window(r_send_lower, r_item.rx_ack, r_send_next);
        // acked run length, sequence space wraps at its width
        w_rel_n     = r_item.rx_ack - r_send_lower + SEQ_W'(1);
        w_seq_slot  = r_item.rx_seq[SLOT_W-1:0];
        w_walk_slot = r_recv_lower[SLOT_W-1:0];
    end

    always_comb begin
        n_send_lower   = r_send_lower;
        n_send_next    = r_send_next;
        n_recv_lower   = r_recv_lower;
        n_recv_upper   = r_recv_upper;
        n_slot_arrived = r_slot_arrived;
        n_outstanding  = r_outstanding;
        n_nak_allowed  = r_nak_allowed;
        n_phys_ready   = r_phys_ready;
        n_walk_act     = r_walk_act;
        n_walk_first   = r_walk_first;
        n_walk_n       = r_walk_n;
        n_q_cnt        = r_q_cnt;
        n_q_head       = r_q_head;
        w_push         = 1'b0;
        w_push_item    = mk_res(ACT_STATUS, '0, '0, 1'b0, 1'b0, 1'b0, w_ack_now);

        case (i_cmd.op)
            OP_EVENT: begin
                case (r_item.mode)
                    MODE_PKT: begin
                        if (r_outstanding < WIN_CNT) begin
                            n_outstanding = r_outstanding + CNT_W'(1);
                            w_push        = 1'b1;
                            w_push_item   = mk_res(ACT_DATA, r_send_next, '0,
                                                   1'b1, 1'b0, 1'b1, w_ack_now);
                            n_send_next   = seq_inc(r_send_next);
                            n_phys_ready  = 1'b0;
                        end
                    end
                    MODE_PHY: begin
                        n_phys_ready = 1'b1;
                    end
                    MODE_FRAME: begin
                        if (!r_item.frame_good) begin
                            if (r_nak_allowed) begin
                                w_push        = 1'b1;
                                w_push_item   = mk_res(ACT_NAK, '0, '0,
                                                       1'b0, 1'b0, 1'b1, w_ack_now);
                                n_phys_ready  = 1'b0;
                                n_nak_allowed = 1'b0;
                            end
                        end else if (r_item.frame_type == FT_DATA) begin
                            if (r_item.rx_seq != r_recv_lower && r_nak_allowed) begin
                                w_push        = 1'b1;
                                w_push_item   = mk_res(ACT_NAK, '0, '0,
                                                       1'b0, 1'b0, 1'b1, w_ack_now);
                                n_phys_ready  = 1'b0;
                                n_nak_allowed = 1'b0;
                            end
                            if (in_window(r_recv_lower, r_item.rx_seq, r_recv_upper) &&
                                !r_slot_arrived[w_seq_slot]) begin
                                n_slot_arrived[w_seq_slot] = 1'b1;
                                n_walk_act   = 1'b1;
                                n_walk_first = r_recv_lower;
                                n_walk_n     = '0;
                            end
                        end
                    end
                    MODE_DTO: begin
                        w_push       = 1'b1;
                        w_push_item  = mk_res(ACT_DATA, r_item.timeout_seq, '0,
                                              1'b1, 1'b0, 1'b1, w_ack_now);
                        n_phys_ready = 1'b0;
                    end
                    MODE_ATO: begin
                        w_push       = 1'b1;
                        w_push_item  = mk_res(ACT_ACK, '0, '0,
                                              1'b0, 1'b0, 1'b1, w_ack_now);
                        n_phys_ready = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            OP_WALK: begin
                // one window slot per cycle
                if (r_slot_arrived[w_walk_slot] && r_walk_n != WIN_CNT) begin
                    n_slot_arrived[w_walk_slot] = 1'b0;
                    n_nak_allowed = 1'b1;
                    n_recv_lower  = seq_inc(r_recv_lower);
                    n_recv_upper  = seq_inc(r_recv_upper);
                    n_walk_n      = r_walk_n + CNT_W'(1);
                end else begin
                    n_walk_act = 1'b0;
                    if (r_walk_n != '0) begin
                        w_push      = 1'b1;
                        w_push_item = mk_res(ACT_DELIVER, r_walk_first, RUN_W'(r_walk_n),
                                             1'b0, 1'b1, 1'b0, w_ack_now);
                    end
                end
            end
            OP_NAKDATA: begin
                if (r_item.frame_type == FT_NAK && w_lost_hit) begin
                    w_push       = 1'b1;
                    w_push_item  = mk_res(ACT_DATA, w_lost, '0,
                                          1'b1, 1'b0, 1'b1, w_ack_now);
                    n_phys_ready = 1'b0;
                end
            end
            OP_RELEASE: begin
                if (w_rel_hit) begin
                    w_push       = 1'b1;
                    w_push_item  = mk_res(ACT_RELEASE, r_send_lower, RUN_W'(w_rel_n),
                                          1'b0, 1'b0, 1'b0, w_ack_now);
                    n_send_lower = w_lost;
                    // outstanding counts down and stops at zero
                    if (r_outstanding > CNT_W'(w_rel_n))
                        n_outstanding = r_outstanding - CNT_W'(w_rel_n);
                    else
                        n_outstanding = '0;
                end
            end
            OP_FILL: begin
                if (r_q_cnt == '0) begin
                    w_push = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_push && r_q_cnt < Q_CNT_W'(MAX_RES))
            n_q_cnt = r_q_cnt + Q_CNT_W'(1);
        if (i_cmd.pop)
            n_q_head = r_q_head + Q_IDX_W'(1);
        if (i_cmd.load) begin
            n_q_cnt  = '0;
            n_q_head = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_lower   <= '0;
            r_send_next    <= '0;
            r_recv_lower   <= '0;
            r_recv_upper   <= RECV_UP_0;
            r_slot_arrived <= '0;
            r_outstanding  <= '0;
            r_nak_allowed  <= 1'b1;
            r_phys_ready   <= 1'b0;
            r_walk_act     <= 1'b0;
            r_walk_n       <= '0;
            r_q_cnt        <= '0;
            r_q_head       <= '0;
        end else begin
            r_send_lower   <= n_send_lower;
            r_send_next    <= n_send_next;
            r_recv_lower   <= n_recv_lower;
            r_recv_upper   <= n_recv_upper;
            r_slot_arrived <= n_slot_arrived;
            r_outstanding  <= n_outstanding;
            r_nak_allowed  <= n_nak_allowed;
            r_phys_ready   <= n_phys_ready;
            r_walk_act     <= n_walk_act;
            r_walk_n       <= n_walk_n;
            r_q_cnt        <= n_q_cnt;
            r_q_head       <= n_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk_first <= n_walk_first;
        if (i_cmd.load)
            r_item <= i_in_item;
        if (w_push && r_q_cnt < Q_CNT_W'(MAX_RES))
            r_q[r_q_cnt[Q_IDX_W-1:0]] <= w_push_item;
    end

    always_comb begin
        w_head_last = (Q_CNT_W'(r_q_head) + Q_CNT_W'(1)) == r_q_cnt;
        w_head      = r_q[r_q_head];
        w_head.net_enable = (r_outstanding < WIN_CNT) && r_phys_ready;
        w_head.last       = w_head_last;
    end

    assign o_out_item       = w_head;
    assign o_stat.frame_ok  = (r_item.mode == MODE_FRAME) && r_item.frame_good;
    assign o_stat.walk_act  = r_walk_act;
    assign o_stat.head_last = w_head_last;

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk_n <= WIN_CNT)
        else $error("delivery walk ran past the window");

    a_outstanding_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= WIN_CNT)
        else $error("outstanding count above window");

    a_walk_ends_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_WALK && r_walk_act && n_walk_act) |=>
            (r_recv_lower == seq_inc($past(r_recv_lower))))
        else $error("walk step did not advance the receive window");

endmodule

/* design/sra_ctrl.sv */
// ----------------------------------------------------------------------------
// sra_ctrl
// event sequencer: accept, event step, delivery walk, release, status fill, drain
// ----------------------------------------------------------------------------
module sra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  sra_pkg::t_stat i_stat,
    output sra_pkg::t_cmd  o_cmd
);
    import sra_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EVENT   = 3'd1;
    localparam logic [2:0] S_WALK    = 3'd2;
    localparam logic [2:0] S_RELEASE = 3'd3;
    localparam logic [2:0] S_FINISH  = 3'd4;
    localparam logic [2:0] S_DRAIN   = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.pop  = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVENT;
                end
            end
            S_EVENT: begin
                o_cmd.op = OP_EVENT;
                n_state  = i_stat.frame_ok ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                if (i_stat.walk_act) begin
                    o_cmd.op = OP_WALK;
                end else begin
                    o_cmd.op = OP_NAKDATA;
                    n_state  = S_RELEASE;
                end
            end
            S_RELEASE: begin
                o_cmd.op = OP_RELEASE;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.op = OP_FILL;
                n_state  = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_out_stall) begin
                    o_cmd.pop = 1'b1;
                    if (i_stat.head_last)
                        n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DRAIN);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while results still pending");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid))
        else $error("accepted word not processed before drain");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && i_stat.head_last) |=> !o_out_valid)
        else $error("output kept valid after final word");

endmodule

/* design/selective_repeat_arq_controller.sv */
// ----------------------------------------------------------------------------
// selective_repeat_arq_controller
// window control of a selective-repeat link protocol
// ----------------------------------------------------------------------------
// One input word is one event: packet ready, physical layer ready, frame
// received, data timeout or ack timeout. The block answers each event with one
// to three command words (send data, ack or nak, deliver an in-order run,
// release an acknowledged run, or status only), the final one flagged by last
// and all of them carrying the network-layer enable taken after the event.
// Events are handled one at a time: the input stalls from acceptance until
// the last command word of that event has been taken. A non-frame event or a
// bad frame passes through the event step, the status fill and the drain,
// which waits out output stalls; a good frame also runs the delivery walk,
// which tests one window slot of the arrived bitmap per cycle, and the
// release step.
// ----------------------------------------------------------------------------
module selective_repeat_arq_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // event words
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sra_pkg::t_in_item  i_in_item,
    // command words
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sra_pkg::t_out_item o_out_item
);
    import sra_pkg::*;

    // control to datapath commands and datapath status back
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: walks each event through its steps and drains the results
    sra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: window bounds, arrived bitmap, flags and result queue
    sra_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_stat     (w_stat),
        .o_out_item (o_out_item)
    );

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the selective-repeat window controller
// ----------------------------------------------------------------------------
// Event words go in with random gaps and command words come out under random
// stalls. A scoreboard keeps its own copy of both windows, the arrived bitmap
// and the flags, and it works out the command words of every accepted event.
// Each command word that leaves the block is checked field by field against
// the oldest word still awaited. Random traffic is mostly well-formed: data
// frames inside the receive window in shuffled order, and acks and naks for
// frames that are really outstanding. Fully random words are mixed in.
// ----------------------------------------------------------------------------
module tb;
    import sra_pkg::*;

    localparam int RANDOM_EVENTS = 240;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int IN_W          = $bits(t_in_item);

    // expected window state of the block, kept by the scoreboard
    class arq_scoreboard;
        logic [SEQ_W-1:0] tx_lo, tx_next, rx_lo, rx_hi;
        bit               rx_held[WIN];
        int unsigned      unacked;
        bit               nak_ok, phy_up;
        t_out_item        want_q[$];
        t_out_item        ev_words[$];
        int               fails;

        function new();
            tx_lo   = '0;
            tx_next = '0;
            rx_lo   = '0;
            rx_hi   = RECV_UP_0;
            unacked = 0;
            nak_ok  = 1'b1;
            phy_up  = 1'b0;
            fails   = 0;
            foreach (rx_held[k]) rx_held[k] = 1'b0;
        endfunction

        // b in the circular span [a, c): distances from a wrap in 6 bits
        function bit in_span(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                             logic [SEQ_W-1:0] c);
            logic [SEQ_W-1:0] db, dc;
            db = b - a;
            dc = c - a;
            return db < dc;
        endfunction

        function void add_word(logic [2:0] act, logic [SEQ_W-1:0] seq,
                               logic [RUN_W-1:0] run, bit sdt, bit rat, bit hat);
            t_out_item w;
            w.action            = act;
            w.seq_out           = seq;
            w.ack_out           = rx_lo - 1'b1;
            w.run_length        = run;
            w.start_data_timer  = sdt;
            w.restart_ack_timer = rat;
            w.halt_ack_timer    = hat;
            w.net_enable        = 1'b0;
            w.last              = 1'b0;
            ev_words.push_back(w);
            // any frame on the line uses up the physical layer
            if (hat) phy_up = 1'b0;
            if (act == ACT_NAK) nak_ok = 1'b0;
        endfunction

        function void take_frame(t_in_item ev);
            logic [SEQ_W-1:0] from, lost;
            int               n;
            if (!ev.frame_good) begin
                if (nak_ok) add_word(ACT_NAK, '0, '0, 1'b0, 1'b0, 1'b1);
                return;
            end
            if (ev.frame_type == FT_DATA) begin
                if (ev.rx_seq != rx_lo && nak_ok) add_word(ACT_NAK, '0, '0, 1'b0, 1'b0, 1'b1);
                if (in_span(rx_lo, ev.rx_seq, rx_hi) && !rx_held[ev.rx_seq[SLOT_W-1:0]]) begin
                    rx_held[ev.rx_seq[SLOT_W-1:0]] = 1'b1;
                    from = rx_lo;
                    n    = 0;
                    while (n < WIN && rx_held[rx_lo[SLOT_W-1:0]]) begin
                        rx_held[rx_lo[SLOT_W-1:0]] = 1'b0;
                        nak_ok = 1'b1;
                        rx_lo++;
                        rx_hi++;
                        n++;
                    end
                    if (n > 0) add_word(ACT_DELIVER, from, RUN_W'(n), 1'b0, 1'b1, 1'b0);
                end
            end
            if (ev.frame_type == FT_NAK) begin
                lost = ev.rx_ack + 1'b1;
                if (in_span(tx_lo, lost, tx_next)) add_word(ACT_DATA, lost, '0, 1'b1, 1'b0, 1'b1);
            end
            // cumulative ack, whatever the kind
            from = tx_lo;
            n    = 0;
            while (n <= SEQ_MAX && in_span(tx_lo, ev.rx_ack, tx_next)) begin
                if (unacked > 0) unacked--;
                tx_lo++;
                n++;
            end
            if (n > 0) add_word(ACT_RELEASE, from, RUN_W'(n), 1'b0, 1'b0, 1'b0);
        endfunction

        function void note_event(t_in_item ev);
            bit en;
            ev_words.delete();
            case (ev.mode)
                MODE_PKT: begin
                    if (unacked < WIN) begin
                        unacked++;
                        add_word(ACT_DATA, tx_next, '0, 1'b1, 1'b0, 1'b1);
                        tx_next++;
                    end
                end
                MODE_PHY:   phy_up = 1'b1;
                MODE_FRAME: take_frame(ev);
                MODE_DTO:   add_word(ACT_DATA, ev.timeout_seq, '0, 1'b1, 1'b0, 1'b1);
                MODE_ATO:   add_word(ACT_ACK, '0, '0, 1'b0, 1'b0, 1'b1);
                default: ;
            endcase
            if (ev_words.size() == 0) add_word(ACT_STATUS, '0, '0, 1'b0, 1'b0, 1'b0);
            en = (unacked < WIN) && phy_up;
            foreach (ev_words[k]) begin
                ev_words[k].net_enable = en;
                ev_words[k].last       = (k == ev_words.size() - 1);
                want_q.push_back(ev_words[k]);
            end
        endfunction

        function void log_fail(string msg);
            fails++;
            if (fails <= 10) $display("%s", msg);
        endfunction

        function void check_word(t_out_item got);
            t_out_item w;
            string     bad;
            if (want_q.size() == 0) begin
                log_fail($sformatf("unexpected command word %p", got));
                return;
            end
            w   = want_q.pop_front();
            bad = "";
            if (got.action !== w.action)                       bad = {bad, " action"};
            if (got.seq_out !== w.seq_out)                     bad = {bad, " seq_out"};
            if (got.ack_out !== w.ack_out)                     bad = {bad, " ack_out"};
            if (got.run_length !== w.run_length)               bad = {bad, " run_length"};
            if (got.start_data_timer !== w.start_data_timer)   bad = {bad, " start_data_timer"};
            if (got.restart_ack_timer !== w.restart_ack_timer) bad = {bad, " restart_ack_timer"};
            if (got.halt_ack_timer !== w.halt_ack_timer)       bad = {bad, " halt_ack_timer"};
            if (got.net_enable !== w.net_enable)               bad = {bad, " net_enable"};
            if (got.last !== w.last)                           bad = {bad, " last"};
            if (bad != "")
                log_fail($sformatf("mismatch in%s: expected %p, got %p", bad, w, got));
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    arq_scoreboard sb = new();

    int unsigned cycle_cnt = 0;
    int          sent      = 0;
    bit          tx_calm   = 1'b0;
    bit          rx_calm   = 1'b0;
    bit          hold_req  = 1'b0;

    selective_repeat_arq_controller i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #10 clk = ~clk;

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // every command word taken is checked
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall) sb.check_word(out_item);

    // receiver: random stalls per word, calm stretches, one long hold-off
    initial begin : receiver
        int gap;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 13);
            repeat (gap) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic send_event(input t_in_item ev);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge clk); while (!(in_valid && !in_stall));
        sb.note_event(ev);
        sent++;
    endtask

    // drop valid and wait for every awaited command word
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.want_q.size() > 0) @(posedge clk);
    endtask

    function automatic t_in_item make_ev(logic [2:0] mode, logic good, logic [1:0] kind,
                                         logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ack,
                                         logic [SEQ_W-1:0] tseq);
        t_in_item e;
        e.mode        = mode;
        e.frame_good  = good;
        e.frame_type  = kind;
        e.rx_seq      = seq;
        e.rx_ack      = ack;
        e.timeout_seq = tseq;
        return e;
    endfunction

    // given event code, every other field random
    function automatic t_in_item noise_ev(logic [2:0] mode);
        t_in_item e;
        e      = IN_W'($urandom);
        e.mode = mode;
        return e;
    endfunction

    // mostly an ack inside the outstanding span, else the one just below it or a random one
    function automatic logic [SEQ_W-1:0] pick_ack();
        logic [SEQ_W-1:0] span;
        span = sb.tx_next - sb.tx_lo;
        case ($urandom_range(0, 5))
            0:       return SEQ_W'($urandom);
            1, 2:    return sb.tx_lo - 1'b1;
            default: return (span == 0) ? sb.tx_lo - 1'b1
                                        : sb.tx_lo + SEQ_W'($urandom_range(0, span - 1));
        endcase
    endfunction

    // k frames beyond the lower edge in shuffled order, then the edge itself
    task automatic data_run(input int k);
        int               offs[$];
        int               i, j, t;
        logic [SEQ_W-1:0] base;
        base = sb.rx_lo;
        for (i = 1; i <= k; i++) offs.push_back(i);
        for (i = k - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = offs[i];
            offs[i] = offs[j];
            offs[j] = t;
        end
        offs.push_back(0);
        foreach (offs[n])
            send_event(make_ev(MODE_FRAME, $urandom_range(0, 11) != 0, FT_DATA,
                               base + SEQ_W'(offs[n]), pick_ack(), SEQ_W'($urandom)));
    endtask

    initial begin : stimulus
        int pick, n, k, first_random;
        bit held, drained;
        held    = 1'b0;
        drained = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opening
        send_event(noise_ev(MODE_PHY));
        send_event(noise_ev(MODE_PKT));
        send_event(noise_ev(MODE_PKT));
        send_event(make_ev(MODE_FRAME, 1'b1, FT_ACK, '0, '0, '0));
        // bad frame with every sequence field at its top, kind beyond nak
        send_event(make_ev(MODE_FRAME, 1'b0, FT_NAK + 2'd1, '1, '1, '1));
        // bad frame again, nak already spent
        send_event(make_ev(MODE_FRAME, 1'b0, FT_DATA, '0, '0, '0));
        // out of order data, held in the bitmap, then the lower edge, delivered alone
        send_event(make_ev(MODE_FRAME, 1'b1, FT_DATA, SEQ_W'(2), '1, '0));
        send_event(make_ev(MODE_FRAME, 1'b1, FT_DATA, '0, SEQ_W'(1), '0));
        // fills the gap, run of two
        send_event(make_ev(MODE_FRAME, 1'b1, FT_DATA, SEQ_W'(1), '1, '0));
        // stale duplicate
        send_event(make_ev(MODE_FRAME, 1'b1, FT_DATA, SEQ_W'(1), '1, '0));
        send_event(noise_ev(MODE_PKT));
        send_event(make_ev(MODE_FRAME, 1'b1, FT_NAK, '0, SEQ_W'(1), '0));
        send_event(make_ev(MODE_FRAME, 1'b1, FT_NAK + 2'd1, '0, SEQ_W'(2), '0));
        send_event(make_ev(MODE_DTO, 1'b0, FT_DATA, '0, '0, '1));
        send_event(make_ev(MODE_DTO, 1'b1, FT_DATA, '1, '1, '0));
        send_event(noise_ev(MODE_ATO));
        // event codes past the last one
        for (k = 1; k <= 3; k++) send_event(noise_ev(MODE_ATO + 3'(k)));
        // data at the upper edge of the receive window, then at sequence top
        send_event(make_ev(MODE_FRAME, 1'b1, FT_DATA, sb.rx_hi, '1, '0));
        send_event(make_ev(MODE_FRAME, 1'b1, FT_DATA, '1, '1, '1));

        first_random = sent;
        while (sent - first_random < RANDOM_EVENTS) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            if (!held && sent - first_random >= 80) begin
                // receiver holds off while packets keep coming past a full window
                held     = 1'b1;
                hold_req = 1'b1;
                repeat (WIN + 3) send_event(noise_ev(MODE_PKT));
            end else if (!drained && sent - first_random >= 170) begin
                drained = 1'b1;
                wait_idle();
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    send_event(IN_W'($urandom));
                else if (pick < 24) begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_event(noise_ev(MODE_PKT));
                end else if (pick < 30)
                    send_event(noise_ev(MODE_PHY));
                else if (pick < 55)
                    data_run(($urandom_range(0, 5) == 0) ? $urandom_range(8, WIN - 1)
                                                         : $urandom_range(0, 7));
                else if (pick < 75)
                    send_event(make_ev(MODE_FRAME, $urandom_range(0, 11) != 0,
                                       $urandom_range(0, 1) ? FT_NAK : FT_ACK,
                                       SEQ_W'($urandom), pick_ack(), SEQ_W'($urandom)));
                else if (pick < 88)
                    send_event(noise_ev(MODE_DTO));
                else
                    send_event(noise_ev(MODE_ATO));
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
design/sra_pkg.sv
design/sra_dpath.sv
design/sra_ctrl.sv
design/selective_repeat_arq_controller.sv
verif/tb.sv
